FILE: sv/smae_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smae_pkg
// types, codes and saturation helpers for the small matrix arithmetic engine
// ----------------------------------------------------------------------------
package smae_pkg;

  // width of the dimension registers
  localparam int DIM_W = 4;

  // configuration register indexes
  localparam logic [2:0] CFG_ROW_COUNT     = 3'd0;
  localparam logic [2:0] CFG_INNER_COUNT   = 3'd1;
  localparam logic [2:0] CFG_OUT_COL_COUNT = 3'd2;
  localparam logic [2:0] CFG_OP_MODE       = 3'd3;
  localparam logic [2:0] CFG_SCALE_FACTOR  = 3'd4;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_RUN    = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    MODE_ADD   = 3'd0,
    MODE_SUB   = 3'd1,
    MODE_MUL   = 3'd2,
    MODE_SCALE = 3'd3,
    MODE_TRANS = 3'd4,
    MODE_CMP   = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_RND,
    S_ACC,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic signed [31:0] elem_value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [31:0] out_value;
    logic               equal_flag;
    logic               last_flag;
  } out_word_t;

  // clip a 33-bit sum to the signed 32-bit range
  function automatic logic signed [31:0] sat_33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return v[31:0];
  endfunction

  // clip a 64-bit value to the signed 32-bit range
  function automatic logic signed [31:0] sat_64(input logic signed [63:0] v);
    logic all_same;
    all_same = (v[63:31] == {33{1'b0}}) || (v[63:31] == {33{1'b1}});
    if (!all_same) begin
      return v[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return v[31:0];
  endfunction

endpackage

FILE: sv/small_matrix_arithmetic_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small_matrix_arithmetic_engine
// Q16.16 matrix add, subtract, multiply, scale, transpose and compare
// ----------------------------------------------------------------------------
// Load words write one element of A or B into on-chip storage; loads outside
// the configured size are dropped. A run word starts the configured operation
// and the block stalls its input until the last result word has been taken.
// Results come out in row-major order with last_flag on the final one;
// compare gives a single word with equal_flag. One 32x32 multiplier, one
// saturating 33-bit adder and one equality compare are shared under a small
// sequencer; each element, or each product for multiply, costs one registered
// memory read. An element steps read, accumulate, output; scale and multiply
// add multiply and round before accumulate, multiply repeats all but output
// per inner term, and compare outputs only after the last element. Sums
// saturate; products round half up, then saturate; the multiply accumulator
// restarts at zero for every output element. Entries never loaded read back
// as whatever the storage holds. Configuration must be written only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module small_matrix_arithmetic_engine #(
  parameter int MAX_DIM = 8
) (
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               cfg_wen,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  // input words
  input  logic               in_valid,
  output logic               in_stall,
  input  smae_pkg::in_word_t in_word,
  // result words
  output logic               out_valid,
  input  logic               out_stall,
  output smae_pkg::out_word_t out_word
);
  import smae_pkg::*;

  localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

  // configuration registers
  logic [DIM_W-1:0]   row_count;
  logic [DIM_W-1:0]   inner_count;
  logic [DIM_W-1:0]   out_col_count;
  logic [2:0]         op_mode;
  logic signed [31:0] scale_factor;

  // matrix storage, row r column c at r*MAX_DIM+c
  logic signed [31:0] mem_a [MEM_DEPTH];
  logic signed [31:0] mem_b [MEM_DEPTH];
  logic signed [31:0] a_rd;
  logic signed [31:0] b_rd;
  logic [ADDR_W-1:0]  a_raddr;
  logic [ADDR_W-1:0]  b_raddr;
  logic [ADDR_W-1:0]  waddr;

  // sequencer
  state_t             state;
  state_t             state_next;
  logic [IDX_W-1:0]   i;
  logic [IDX_W-1:0]   j;
  logic [IDX_W-1:0]   k;
  logic               eq_acc;

  // shared datapath registers
  logic signed [63:0] prod;
  logic signed [31:0] q;
  logic signed [31:0] acc;

  // working dimensions, clamped to 1..MAX_DIM
  logic [DIM_W-1:0]   nr;
  logic [DIM_W-1:0]   ni;
  logic [DIM_W-1:0]   nc;
  logic [DIM_W-1:0]   row_lim;
  logic [DIM_W-1:0]   col_lim;

  logic               in_accept;
  logic               run_ok;
  logic               load_a_ok;
  logic               load_b_ok;
  logic               is_mul;
  logic               is_scale;
  logic               is_cmp;
  logic               j_last;
  logic               k_last;
  logic               last_elem;
  logic               a_eq;

  // shared saturating adder
  logic signed [31:0] alu_x;
  logic signed [31:0] alu_y;
  logic               alu_sub;
  logic signed [32:0] alu_raw;
  logic signed [31:0] alu_sum;
  logic signed [31:0] mul_rhs;

  function automatic logic [ADDR_W-1:0] elem_addr(input logic [2:0] r,
                                                  input logic [2:0] c);
    return ADDR_W'(int'(r) * MAX_DIM + int'(c));
  endfunction

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count     <= DIM_W'(3);
      inner_count   <= DIM_W'(3);
      out_col_count <= DIM_W'(3);
      op_mode       <= MODE_ADD;
      scale_factor  <= 32'sd65536;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_ROW_COUNT:     row_count     <= cfg_wdata[DIM_W-1:0];
        CFG_INNER_COUNT:   inner_count   <= cfg_wdata[DIM_W-1:0];
        CFG_OUT_COL_COUNT: out_col_count <= cfg_wdata[DIM_W-1:0];
        CFG_OP_MODE:       op_mode       <= cfg_wdata[2:0];
        CFG_SCALE_FACTOR:  scale_factor  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    nr = (row_count == '0) ? DIM_W'(1) : (row_count > DIM_MAX) ? DIM_MAX : row_count;
    ni = (inner_count == '0) ? DIM_W'(1) :
         (inner_count > DIM_MAX) ? DIM_MAX : inner_count;
    nc = (out_col_count == '0) ? DIM_W'(1) :
         (out_col_count > DIM_MAX) ? DIM_MAX : out_col_count;
  end

  assign is_mul   = (op_mode == MODE_MUL);
  assign is_scale = (op_mode == MODE_SCALE);
  assign is_cmp   = (op_mode == MODE_CMP);
  assign run_ok   = (op_mode <= MODE_CMP);

  // shape of the walk: transpose runs over A's columns, multiply over B's
  assign row_lim = (op_mode == MODE_TRANS) ? ni : nr;
  assign col_lim = is_mul ? nc : (op_mode == MODE_TRANS) ? nr : ni;

  assign j_last    = (DIM_W'(j) == col_lim - DIM_W'(1));
  assign k_last    = (DIM_W'(k) == ni - DIM_W'(1));
  assign last_elem = (DIM_W'(i) == row_lim - DIM_W'(1)) && j_last;

  // --------------------------------------------------------------------------
  // loads
  // --------------------------------------------------------------------------
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign load_a_ok = (DIM_W'(in_word.row_index) < nr) && (DIM_W'(in_word.col_index) < ni);
  assign load_b_ok = is_mul ?
                     ((DIM_W'(in_word.row_index) < ni) && (DIM_W'(in_word.col_index) < nc)) :
                     load_a_ok;
  assign waddr     = elem_addr(in_word.row_index, in_word.col_index);

  // read addresses follow the loop counters
  always_comb begin
    if (is_mul) begin
      a_raddr = elem_addr(3'(i), 3'(k));
      b_raddr = elem_addr(3'(k), 3'(j));
    end else if (op_mode == MODE_TRANS) begin
      a_raddr = elem_addr(3'(j), 3'(i));
      b_raddr = elem_addr(3'(i), 3'(j));
    end else begin
      a_raddr = elem_addr(3'(i), 3'(j));
      b_raddr = elem_addr(3'(i), 3'(j));
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && (in_word.operation == OP_LOAD_A) && load_a_ok) begin
      mem_a[waddr] <= in_word.elem_value;
    end
    a_rd <= mem_a[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (in_accept && (in_word.operation == OP_LOAD_B) && load_b_ok) begin
      mem_b[waddr] <= in_word.elem_value;
    end
    b_rd <= mem_b[b_raddr];
  end

  // --------------------------------------------------------------------------
  // shared arithmetic
  // --------------------------------------------------------------------------
  assign mul_rhs = is_mul ? b_rd : scale_factor;
  assign a_eq    = (a_rd == b_rd);

  always_comb begin
    alu_x   = a_rd;
    alu_y   = '0;
    alu_sub = 1'b0;
    case (op_mode)
      MODE_ADD: begin
        alu_y = b_rd;
      end
      MODE_SUB: begin
        alu_y   = b_rd;
        alu_sub = 1'b1;
      end
      MODE_MUL: begin
        // accumulator restarts at zero on the first product of an element
        alu_x = (k == '0) ? '0 : acc;
        alu_y = q;
      end
      MODE_SCALE: begin
        alu_x = '0;
        alu_y = q;
      end
      default: ;
    endcase
  end

  assign alu_raw = alu_sub ? (33'(alu_x) - 33'(alu_y)) : (33'(alu_x) + 33'(alu_y));
  assign alu_sum = sat_33(alu_raw);

  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      prod <= a_rd * mul_rhs;
    end
    if (state == S_RND) begin
      // round half up, then drop the 16 fraction bits
      q <= sat_64((prod + 64'sd32768) >>> 16);
    end
    if (state == S_ACC) begin
      acc <= alu_sum;
      if (is_cmp) begin
        out_word.out_row    <= '0;
        out_word.out_col    <= '0;
        out_word.out_value  <= '0;
        out_word.equal_flag <= eq_acc && a_eq;
        out_word.last_flag  <= 1'b1;
      end else begin
        out_word.out_row    <= 3'(i);
        out_word.out_col    <= 3'(j);
        out_word.out_value  <= alu_sum;
        out_word.equal_flag <= 1'b0;
        out_word.last_flag  <= last_elem;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept && (in_word.operation == OP_RUN) && run_ok) begin
          state_next = S_READ;
        end
      end
      S_READ: state_next = (is_mul || is_scale) ? S_MUL : S_ACC;
      S_MUL:  state_next = S_RND;
      S_RND:  state_next = S_ACC;
      S_ACC: begin
        if (is_mul) begin
          state_next = k_last ? S_OUT : S_READ;
        end else if (is_cmp) begin
          state_next = last_elem ? S_OUT : S_READ;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_next = last_elem ? S_IDLE : S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid = (state == S_OUT);

  // loop counters and the compare flag
  always_ff @(posedge clk) begin
    if (rst) begin
      i      <= '0;
      j      <= '0;
      k      <= '0;
      eq_acc <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept && (in_word.operation == OP_RUN)) begin
            i      <= '0;
            j      <= '0;
            k      <= '0;
            eq_acc <= 1'b1;
          end
        end
        S_ACC: begin
          if (is_mul && !k_last) begin
            k <= k + 1'b1;
          end
          if (is_cmp) begin
            eq_acc <= eq_acc && a_eq;
            if (!last_elem) begin
              if (j_last) begin
                j <= '0;
                i <= i + 1'b1;
              end else begin
                j <= j + 1'b1;
              end
            end
          end
        end
        S_OUT: begin
          if (!out_stall && !last_elem) begin
            k <= '0;
            if (j_last) begin
              j <= '0;
              i <= i + 1'b1;
            end else begin
              j <= j + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  // an idle block holds no undelivered word
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("result word pending while input is open");

  // the compare flag only appears on a closing word
  a_flag_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.equal_flag |-> out_word.last_flag)
    else $error("equal flag on a word that is not last");

  // taking the last word of a run reopens the input
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_word.last_flag |=> !in_stall)
    else $error("block did not return to idle after last word");

  // the walk stays inside the configured shape
  a_in_bounds: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (DIM_W'(i) < row_lim) && (DIM_W'(j) < col_lim) && (DIM_W'(k) < ni))
    else $error("loop counter outside matrix shape");

  // only multiply uses the inner counter
  a_k_idle: assert property (@(posedge clk) disable iff (rst)
    in_stall && !is_mul |-> (k == '0))
    else $error("inner counter moved outside multiply");

endmodule

FILE: tb/small_matrix_arithmetic_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small_matrix_arithmetic_engine_tb
// self-checking bench for the Q16.16 matrix engine
// ----------------------------------------------------------------------------
// A stimulus process queues load and run words phase by phase and rewrites the
// configuration between phases while the engine is idle. A clocked driver
// feeds the queue into the engine with random gaps, and a clocked monitor
// mirrors every accepted word into a software copy of both matrices, works out
// the result words each run must give, and compares them field by field with
// what the engine sends back under random output stall. The bench keeps track
// of which matrix entries hold data and loads any missing ones before a run,
// so the engine never reads storage that was not written.
// ----------------------------------------------------------------------------
module small_matrix_arithmetic_engine_tb;
  import smae_pkg::*;

  localparam int MAX_DIM       = 8;
  localparam int IDLE_PCT      = 6;
  localparam int RAND_TARGET   = 400;
  // extra wait in settle once every word and result word is through
  localparam int SETTLE_CYCLES = 40;

  // codes the package leaves unnamed
  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [2:0] MODE_UNUSED_7 = 3'd7;

  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wen = 1'b0;
  logic [2:0] cfg_index = CFG_ROW_COUNT;
  logic [31:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_word_t   in_word = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_word;

  small_matrix_arithmetic_engine #(
    .MAX_DIM(MAX_DIM)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wen(cfg_wen),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word)
  );

  always #1 clk = ~clk;

  // words waiting for the driver, and result words still owed by the engine
  in_word_t  matrix_cmds[$];
  out_word_t result_words_due[$];

  int error_count = 0;
  int cmds_counted = 0;
  bit calm = 1'b0;     // no gaps and no stall on either side while set
  bit in_fired = 1'b0; // input word taken at the last rising edge

  // ---------------------------------------------------------------------------
  // predictor state: matrix copies and register copies as the engine sees them
  // ---------------------------------------------------------------------------
  logic signed [31:0] mat_a [MAX_DIM*MAX_DIM];
  logic signed [31:0] mat_b [MAX_DIM*MAX_DIM];
  logic [3:0]         cfg_rows, cfg_inner, cfg_cols;
  logic [2:0]         cfg_mode;
  logic signed [31:0] cfg_scale;

  // ---------------------------------------------------------------------------
  // stimulus shadow: what has been queued so far, used to plan loads
  // ---------------------------------------------------------------------------
  logic signed [31:0] gen_a_val [MAX_DIM*MAX_DIM];
  logic signed [31:0] gen_b_val [MAX_DIM*MAX_DIM];
  bit                 gen_a_ok [MAX_DIM*MAX_DIM];
  bit                 gen_b_ok [MAX_DIM*MAX_DIM];
  logic [3:0]         gen_rows = 4'd3, gen_inner = 4'd3, gen_cols = 4'd3;
  logic [2:0]         gen_mode = MODE_ADD;

  // working size of a dimension register, held to 1..MAX_DIM
  function automatic int dim_of(logic [3:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // whether a load lands inside the configured size
  function automatic bit load_fits(logic [1:0] op, int r, int c, int nr, int ni,
                                   int nc, logic [2:0] mode);
    if (op == OP_LOAD_A) return r < nr && c < ni;
    if (op == OP_LOAD_B) return (mode == MODE_MUL) ? (r < ni && c < nc) : (r < nr && c < ni);
    return 1'b0;
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return v[31:0];
  endfunction

  // Q16.16 product: exact, plus half an lsb, arithmetic shift, then clip
  function automatic logic signed [31:0] q_mul(logic signed [31:0] x, logic signed [31:0] y);
    longint p;
    p = (longint'(x) * longint'(y) + 64'sd32768) >>> 16;
    return clip32(p);
  endfunction

  task automatic queue_result(int r, int c, logic signed [31:0] v, bit eq, bit last);
    out_word_t o;
    o.out_row    = 3'(r);
    o.out_col    = 3'(c);
    o.out_value  = v;
    o.equal_flag = eq;
    o.last_flag  = last;
    result_words_due.push_back(o);
  endtask

  // update the matrix copies for one accepted word, queue what a run must emit
  task automatic apply_matrix_cmd(in_word_t w);
    int nr, ni, nc, idx;
    logic signed [31:0] acc, res;
    bit same;
    nr = dim_of(cfg_rows);
    ni = dim_of(cfg_inner);
    nc = dim_of(cfg_cols);
    idx = w.row_index * MAX_DIM + w.col_index;
    if (w.operation == OP_LOAD_A || w.operation == OP_LOAD_B) begin
      if (load_fits(w.operation, w.row_index, w.col_index, nr, ni, nc, cfg_mode)) begin
        if (w.operation == OP_LOAD_A) mat_a[idx] = w.elem_value;
        else mat_b[idx] = w.elem_value;
      end
    end else if (w.operation == OP_RUN) begin
      case (cfg_mode)
        MODE_ADD, MODE_SUB, MODE_SCALE: begin
          for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < ni; j++) begin
              idx = i * MAX_DIM + j;
              if (cfg_mode == MODE_ADD) begin
                res = clip32(longint'(mat_a[idx]) + longint'(mat_b[idx]));
              end else if (cfg_mode == MODE_SUB) begin
                res = clip32(longint'(mat_a[idx]) - longint'(mat_b[idx]));
              end else begin
                res = q_mul(mat_a[idx], cfg_scale);
              end
              queue_result(i, j, res, 1'b0, i == nr - 1 && j == ni - 1);
            end
          end
        end
        MODE_MUL: begin
          // accumulator restarts at zero per element and clips after each add
          for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
              acc = '0;
              for (int k = 0; k < ni; k++) begin
                acc = clip32(longint'(acc) + longint'(q_mul(mat_a[i*MAX_DIM+k],
                                                              mat_b[k*MAX_DIM+j])));
              end
              queue_result(i, j, acc, 1'b0, i == nr - 1 && j == nc - 1);
            end
          end
        end
        MODE_TRANS: begin
          // result is inner_count rows by row_count columns
          for (int i = 0; i < ni; i++) begin
            for (int j = 0; j < nr; j++) begin
              queue_result(i, j, mat_a[j*MAX_DIM+i], 1'b0, i == ni - 1 && j == nr - 1);
            end
          end
        end
        MODE_CMP: begin
          same = 1'b1;
          for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < ni; j++) begin
              if (mat_a[i*MAX_DIM+j] != mat_b[i*MAX_DIM+j]) same = 1'b0;
            end
          end
          queue_result(0, 0, '0, same, 1'b1);
        end
        default: ; // unused modes give nothing
      endcase
    end
  endtask

  task automatic check_field(string name, logic signed [32:0] want, logic signed [32:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      error_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitor: config mirror, input word capture, result word check
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    out_word_t want;
    if (rst) begin
      cfg_rows  = 4'd3;
      cfg_inner = 4'd3;
      cfg_cols  = 4'd3;
      cfg_mode  = MODE_ADD;
      cfg_scale = Q_ONE;
      in_fired  = 1'b0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          CFG_ROW_COUNT:     cfg_rows  = cfg_wdata[3:0];
          CFG_INNER_COUNT:   cfg_inner = cfg_wdata[3:0];
          CFG_OUT_COL_COUNT: cfg_cols  = cfg_wdata[3:0];
          CFG_OP_MODE:       cfg_mode  = cfg_wdata[2:0];
          CFG_SCALE_FACTOR:  cfg_scale = cfg_wdata;
          default: ;
        endcase
      end
      in_fired = in_valid && !in_stall;
      if (in_fired) apply_matrix_cmd(in_word);
      if (out_valid && !out_stall) begin
        if (result_words_due.size() == 0) begin
          $error("result word with none pending: row %0d col %0d value %0d",
                 out_word.out_row, out_word.out_col, out_word.out_value);
          error_count++;
        end else begin
          want = result_words_due.pop_front();
          check_field("out_row", want.out_row, out_word.out_row);
          check_field("out_col", want.out_col, out_word.out_col);
          check_field("out_value", want.out_value, out_word.out_value);
          check_field("equal_flag", want.equal_flag, out_word.equal_flag);
          check_field("last_flag", want.last_flag, out_word.last_flag);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driver: input words and output stall change on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fired) begin
      // a stalled word stays put; otherwise offer the next one or take a gap
      if (matrix_cmds.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_word  <= matrix_cmds.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // element values leaning on the saturation and rounding corners
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return Q_ONE;
      4: return -Q_ONE;
      5: return 32'($urandom_range(32'h0003_ffff)) - 32'sh0002_0000;
      default: return $urandom;
    endcase
  endfunction

  // dimension register value: mostly small, sometimes full or out of range
  function automatic logic [3:0] pick_dim();
    case ($urandom_range(11))
      0: return 4'd0;
      1: return 4'(MAX_DIM);
      2: return 4'($urandom_range(MAX_DIM + 1, 15));
      default: return 4'($urandom_range(1, 4));
    endcase
  endfunction

  // queue one word and track which entries it fills
  task automatic push_cmd(logic [1:0] op, int r, int c, logic signed [31:0] v);
    in_word_t w;
    int idx;
    w.operation  = op;
    w.row_index  = 3'(r);
    w.col_index  = 3'(c);
    w.elem_value = v;
    idx = r * MAX_DIM + c;
    matrix_cmds.push_back(w);
    if (load_fits(op, r, c, dim_of(gen_rows), dim_of(gen_inner), dim_of(gen_cols),
                  gen_mode)) begin
      cmds_counted++;
      if (op == OP_LOAD_A) begin
        gen_a_val[idx] = v;
        gen_a_ok[idx]  = 1'b1;
      end else begin
        gen_b_val[idx] = v;
        gen_b_ok[idx]  = 1'b1;
      end
    end else if (op == OP_RUN) begin
      cmds_counted++;
    end
  endtask

  // fill whatever the run will read but was never loaded, then queue the run;
  // with copy_ok a compare run may first get B loaded equal to A
  task automatic push_run(bit copy_ok);
    int nr, ni, nc, br, bc;
    bit need_b, copy_b;
    nr = dim_of(gen_rows);
    ni = dim_of(gen_inner);
    nc = dim_of(gen_cols);
    if (gen_mode <= MODE_CMP) begin
      for (int r = 0; r < nr; r++) begin
        for (int c = 0; c < ni; c++) begin
          if (!gen_a_ok[r*MAX_DIM+c]) push_cmd(OP_LOAD_A, r, c, pick_value());
        end
      end
    end
    need_b = gen_mode == MODE_ADD || gen_mode == MODE_SUB || gen_mode == MODE_MUL ||
             gen_mode == MODE_CMP;
    copy_b = copy_ok && gen_mode == MODE_CMP && $urandom_range(1);
    br = (gen_mode == MODE_MUL) ? ni : nr;
    bc = (gen_mode == MODE_MUL) ? nc : ni;
    if (need_b) begin
      for (int r = 0; r < br; r++) begin
        for (int c = 0; c < bc; c++) begin
          if (copy_b) push_cmd(OP_LOAD_B, r, c, gen_a_val[r*MAX_DIM+c]);
          else if (!gen_b_ok[r*MAX_DIM+c]) push_cmd(OP_LOAD_B, r, c, pick_value());
        end
      end
    end
    push_cmd(OP_RUN, $urandom_range(7), $urandom_range(7), $urandom);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_ROW_COUNT:     gen_rows  = data[3:0];
      CFG_INNER_COUNT:   gen_inner = data[3:0];
      CFG_OUT_COL_COUNT: gen_cols  = data[3:0];
      CFG_OP_MODE:       gen_mode  = data[2:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  // wait until every word is taken and every result word is back, then let
  // a run that gives no result finish before the registers change
  task automatic settle();
    @(posedge clk);
    while (matrix_cmds.size() != 0 || in_valid || result_words_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic signed [31:0] dir_a [9];
    logic signed [31:0] dir_b [9];
    logic [3:0] d_rows, d_inner, d_cols;
    logic [2:0] mode;
    int phase, nr, ni, nc, rows_lim, cols_lim;
    bit pick_b, mul_b;

    dir_a = '{Q_MAX, Q_MIN, Q_ONE, -Q_ONE, 32'sh0000_8000, 32'sh7fff_0000,
              32'sd1, -32'sd1, 32'sd0};
    dir_b = '{Q_MAX, Q_MAX, Q_MIN, 32'sd1, 32'shffff_8000, 32'sh0002_0000,
              Q_MIN, 32'sh0000_8000, 32'sd0};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at the reset size of 3x3x3
    push_cmd(OP_UNUSED, 1, 2, Q_MAX);      // unused operation code, dropped
    push_cmd(OP_LOAD_A, 7, 7, Q_MIN);      // outside the size, dropped
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        push_cmd(OP_LOAD_A, r, c, dir_a[r*3+c]);
        push_cmd(OP_LOAD_B, r, c, dir_b[r*3+c]);
      end
    end
    push_run(1'b0);                        // add in the reset mode
    settle();
    cfg_write(CFG_OP_MODE, MODE_SUB);
    push_run(1'b0);
    settle();
    cfg_write(CFG_OP_MODE, MODE_MUL);
    push_run(1'b0);
    settle();
    cfg_write(CFG_OP_MODE, MODE_SCALE);    // reset factor of one
    push_run(1'b0);
    settle();
    cfg_write(CFG_SCALE_FACTOR, Q_MIN);
    push_run(1'b0);
    settle();
    cfg_write(CFG_OP_MODE, MODE_TRANS);
    push_run(1'b0);
    settle();
    cfg_write(CFG_OP_MODE, MODE_CMP);
    push_run(1'b0);
    settle();
    cfg_write(CFG_OP_MODE, MODE_UNUSED_7); // run gives no result word
    push_run(1'b0);
    settle();

    // random phases, each with its own configuration
    cmds_counted = 0;
    phase = 0;
    while (cmds_counted < RAND_TARGET) begin
      calm = phase >= 3 && phase < 7;
      mode = ($urandom_range(9) == 0) ? 3'($urandom_range(MODE_UNUSED_6, MODE_UNUSED_7))
                                      : 3'($urandom_range(MODE_CMP));
      if (phase == 0) begin
        // largest shape, full multiplies
        d_rows  = 4'(MAX_DIM);
        d_inner = 4'(MAX_DIM);
        d_cols  = 4'(MAX_DIM);
        mode    = MODE_MUL;
      end else if (phase == 1) begin
        d_rows  = 4'd1;
        d_inner = 4'd1;
        d_cols  = 4'd1;
      end else begin
        d_rows  = pick_dim();
        d_inner = pick_dim();
        d_cols  = pick_dim();
      end
      // upper data bits are junk the registers must ignore
      cfg_write(CFG_ROW_COUNT, {28'($urandom), d_rows});
      cfg_write(CFG_INNER_COUNT, {28'($urandom), d_inner});
      cfg_write(CFG_OUT_COL_COUNT, {28'($urandom), d_cols});
      cfg_write(CFG_OP_MODE, {29'($urandom), mode});
      cfg_write(CFG_SCALE_FACTOR, pick_value());
      nr = dim_of(gen_rows);
      ni = dim_of(gen_inner);
      nc = dim_of(gen_cols);
      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(9) == 0) begin
            // noise: any index, possibly outside the size or an unused code
            case ($urandom_range(2))
              0: push_cmd(OP_LOAD_A, $urandom_range(7), $urandom_range(7), pick_value());
              1: push_cmd(OP_LOAD_B, $urandom_range(7), $urandom_range(7), pick_value());
              default: push_cmd(OP_UNUSED, $urandom_range(7), $urandom_range(7), $urandom);
            endcase
          end else begin
            pick_b   = $urandom_range(1);
            mul_b    = pick_b && gen_mode == MODE_MUL;
            rows_lim = mul_b ? ni : nr;
            cols_lim = mul_b ? nc : ni;
            push_cmd(pick_b ? OP_LOAD_B : OP_LOAD_A, $urandom_range(rows_lim - 1),
                     $urandom_range(cols_lim - 1), pick_value());
          end
        end
        push_run(1'b1);
      end
      settle();
      phase++;
    end

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
